### sv/cmat_pkg.sv
// Shared types and constants of the cartridge address translator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cmat_pkg;

   // Bus commands
   localparam logic [1:0] CMD_CPU_READ  = 2'd0;
   localparam logic [1:0] CMD_CPU_WRITE = 2'd1;
   localparam logic [1:0] CMD_VID_READ  = 2'd2;
   localparam logic [1:0] CMD_VID_WRITE = 2'd3;

   // Target stores
   localparam logic [2:0] TGT_NONE      = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
   localparam logic [2:0] TGT_SAVE_RAM  = 3'd2;
   localparam logic [2:0] TGT_CHR_ROM   = 3'd3;
   localparam logic [2:0] TGT_CHR_RAM   = 3'd4;
   localparam logic [2:0] TGT_NAMETABLE = 3'd5;
   localparam logic [2:0] TGT_PALETTE   = 3'd6;

   // Configuration register indexes
   localparam logic [2:0] CSR_MAPPER    = 3'd0;
   localparam logic [2:0] CSR_PRG_COUNT = 3'd1;
   localparam logic [2:0] CSR_CHR_COUNT = 3'd2;
   localparam logic [2:0] CSR_CHR_RAM   = 3'd3;
   localparam logic [2:0] CSR_MIRRORING = 3'd4;

   // Mapper kinds
   localparam logic [7:0] MAP_SERIAL   = 8'd1;
   localparam logic [7:0] MAP_M2       = 8'd2;
   localparam logic [7:0] MAP_M3       = 8'd3;
   localparam logic [7:0] MAP_SEL      = 8'd4;
   localparam logic [7:0] MAP_M7       = 8'd7;
   localparam logic [7:0] MAP_LATCH9   = 8'd9;
   localparam logic [7:0] MAP_LATCH10  = 8'd10;
   localparam logic [7:0] MAP_M34      = 8'd34;
   localparam logic [7:0] MAP_M66      = 8'd66;
   localparam logic [7:0] MAP_CMD      = 8'd69;
   localparam logic [7:0] MAP_M87      = 8'd87;
   localparam logic [7:0] MAP_M94      = 8'd94;
   localparam logic [7:0] MAP_M180     = 8'd180;
   localparam logic [7:0] MAP_M185     = 8'd185;
   localparam logic [7:0] MAP_SEL_FIX  = 8'd206;

   // Bank count limits and remainder unit sizing
   localparam int MaxBanks  = 256;
   localparam int NumWidth  = 11;
   localparam int DivSteps  = NumWidth;
   localparam int StepWidth = $clog2(DivSteps);

   // Which size the raw offset is reduced by
   typedef enum logic [1:0] {
      MOD_NONE = 2'd0,
      MOD_PRG  = 2'd1,
      MOD_CHR  = 2'd2
   } mod_sel_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_step;
   } dp_status_type;

endpackage
`default_nettype wire

### sv/cartridge_mapper_address_translation.sv
// Top level of the cartridge address translator.
// Depends on cmat_pkg, cmat_ctrl and cmat_dp.
//
//  channel | ports     | payload
//  --------+-----------+-------------------------------------------------
//  request | req_*     | tdata: address[15:0], write_data[23:16]; tuser: command
//  result  | rsp_*     | tdata: offset[21:0], zero[23:22]; tuser: target
//  config  | csr_*     | csr_index selects the register, csr_data its value
//
// A request runs through the accept cycle, which computes the raw offset and
// updates bank registers, then eleven iterations of the shared remainder unit,
// which reduce the bank number by the ROM size, and then the done state, which
// loads the result register once it is free. A new request is accepted only
// after the previous one has gone to the result register. Reset is synchronous and clears
// all bank state. The result register frees the core, so a waiting result
// stalls only the hand-off of the next one. csr_ready stays high.
`timescale 1ns / 1ps
`default_nettype none
module cartridge_mapper_address_translation (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // address[15:0], write_data[23:16]
   input  wire  [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // offset[21:0], zero fill[23:22]
   output logic [2:0]  rsp_tuser,   // target[2:0]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [8:0]  csr_data
);

   cmat_pkg::dp_cmd_type    dp_cmd;
   cmat_pkg::dp_status_type dp_status;
   logic [21:0]             offset;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {2'b00, offset};

   cmat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   cmat_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_command    (req_tuser),
      .req_address    (req_tdata[15:0]),
      .req_write_data (req_tdata[23:16]),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_target     (rsp_tuser),
      .rsp_offset     (offset)
   );

endmodule
`default_nettype wire

### sv/cmat_ctrl.sv
// Sequencing controller: accept, remainder iterations, result hand-off.
// Depends on cmat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmat_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output cmat_pkg::dp_cmd_type    dp_cmd,
   input  cmat_pkg::dp_status_type dp_status
);

   cmat_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign req_tready = (state_ff == cmat_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      dp_cmd        = '0;
      unique case (state_ff)
         cmat_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.load = 1'b1;
               state_in    = cmat_pkg::ST_DIV;
            end
         end
         cmat_pkg::ST_DIV: begin
            dp_cmd.step = 1'b1;
            if (dp_status.last_step) state_in = cmat_pkg::ST_DONE;
         end
         cmat_pkg::ST_DONE: begin
            if (slot_free) begin
               dp_cmd.finish = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = cmat_pkg::ST_IDLE;
            end
         end
         default: state_in = cmat_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmat_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### sv/cmat_dp.sv
// Datapath: configuration, bank registers, raw offset, serial remainder, result.
// Depends on cmat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cmat_dp (
   input  wire                     clock,
   input  wire                     reset,
   input  cmat_pkg::dp_cmd_type     dp_cmd,
   output cmat_pkg::dp_status_type  dp_status,
   input  wire  [1:0]              req_command,
   input  wire  [15:0]             req_address,
   input  wire  [7:0]              req_write_data,
   input  wire                     csr_write,
   input  wire  [2:0]              csr_index,
   input  wire  [8:0]              csr_data,
   output logic [2:0]              rsp_target,
   output logic [21:0]             rsp_offset
);

   // Configuration
   logic [7:0] mapper_ff;
   logic [8:0] prg_count_ff, chr_count_ff;
   logic       chr_ram_ff;

   // Bank state
   logic [1:0] mir_ff, mir_in;
   logic [4:0] ser_shift_ff, ser_shift_in;
   logic [2:0] ser_count_ff, ser_count_in;
   logic [4:0] ser_ctrl_ff, ser_ctrl_in;
   logic [4:0] ser_bank_ff [3], ser_bank_in [3];
   logic [7:0] rom_bank_ff, rom_bank_in;
   logic [1:0] pat_bank_ff, pat_bank_in;
   logic [7:0] sel_bank_ff [8], sel_bank_in [8];
   logic [7:0] sel_mode_ff, sel_mode_in;
   logic [4:0] lat_bank_ff [4], lat_bank_in [4];
   logic       latch_ff [2], latch_in [2];
   logic [3:0] cmd_idx_ff, cmd_idx_in;
   logic [7:0] cmd_chr_ff [8], cmd_chr_in [8];
   logic [5:0] cmd_prg_ff [4], cmd_prg_in [4];

   // Work registers
   logic [2:0]            target_ff, target_in;
   logic [23:0]           raw_ff, raw_in;
   cmat_pkg::mod_sel_type sel_ff, sel_in;
   logic [cmat_pkg::NumWidth-1:0]  num_ff;
   logic [7:0]            rem_ff;
   logic [cmat_pkg::StepWidth-1:0] step_ff;
   logic [2:0]            out_target_ff;
   logic [21:0]           out_offset_ff;

   // Clamped bank counts
   logic [8:0] n_prg, n_chr, divisor;
   assign n_prg = (prg_count_ff == 9'd0) ? 9'd1 :
                  (prg_count_ff > 9'(cmat_pkg::MaxBanks)) ? 9'(cmat_pkg::MaxBanks) : prg_count_ff;
   assign n_chr = (chr_count_ff == 9'd0) ? 9'd1 :
                  (chr_count_ff > 9'(cmat_pkg::MaxBanks)) ? 9'(cmat_pkg::MaxBanks) : chr_count_ff;
   assign divisor = (sel_ff == cmat_pkg::MOD_PRG) ? n_prg : n_chr;

   logic [15:0] a;
   logic [7:0]  v;
   logic [13:0] va;
   logic [14:0] off;
   logic        is_sel4, is_sel;
   assign a   = req_address;
   assign v   = req_write_data;
   assign va  = a[13:0];
   assign off = a[14:0];
   assign is_sel4 = (mapper_ff == cmat_pkg::MAP_SEL);
   assign is_sel  = is_sel4 || (mapper_ff == cmat_pkg::MAP_SEL_FIX);

   // Program ROM raw offset
   logic [23:0] prg_raw;
   logic [3:0]  ser_prg;
   logic [9:0]  sel_b;
   logic [7:0]  r6, r7;
   logic [9:0]  n2;
   always_comb begin
      ser_prg = ser_bank_ff[2][3:0];
      n2      = {n_prg, 1'b0};
      r6      = sel_bank_ff[6];
      r7      = sel_bank_ff[7];
      if (!is_sel4) begin
         r6 = {4'd0, r6[3:0]};
         r7 = {4'd0, r7[3:0]};
      end
      if (a < 16'hA000)      sel_b = (is_sel4 && sel_mode_ff[6]) ? n2 - 10'd2 : 10'(r6);
      else if (a < 16'hC000) sel_b = 10'(r7);
      else if (a < 16'hE000) sel_b = (is_sel4 && sel_mode_ff[6]) ? 10'(r6) : n2 - 10'd2;
      else                   sel_b = n2 - 10'd1;
      case (mapper_ff) inside
         cmat_pkg::MAP_SERIAL: begin
            if (!ser_ctrl_ff[3])
               prg_raw = (24'(ser_prg[3:1]) << 15) + 24'(off);
            else if (!ser_ctrl_ff[2])
               prg_raw = (a < 16'hC000) ? 24'(off) : (24'(ser_prg) << 14) + 24'(a[13:0]);
            else
               prg_raw = (a < 16'hC000) ? (24'(ser_prg) << 14) + 24'(off)
                                        : (24'(n_prg - 9'd1) << 14) + 24'(a[13:0]);
         end
         cmat_pkg::MAP_M2, cmat_pkg::MAP_M94, cmat_pkg::MAP_LATCH10:
            prg_raw = (a < 16'hC000) ? (24'(rom_bank_ff) << 14) + 24'(off)
                                     : (24'(n_prg - 9'd1) << 14) + 24'(a[13:0]);
         cmat_pkg::MAP_SEL, cmat_pkg::MAP_SEL_FIX:
            prg_raw = {1'b0, sel_b, a[12:0]};
         cmat_pkg::MAP_M7, cmat_pkg::MAP_M34, cmat_pkg::MAP_M66:
            prg_raw = (24'(rom_bank_ff) << 15) + 24'(off);
         cmat_pkg::MAP_LATCH9:
            prg_raw = (a < 16'hA000) ? (24'(rom_bank_ff) << 13) + 24'(off)
                    : (24'(n_prg) << 15) - 24'h6000 + 24'(a - 16'hA000);
         cmat_pkg::MAP_CMD:
            prg_raw = (a < 16'hE000) ? {3'd0, 8'(cmd_prg_ff[2'd1 + off[14:13]]), a[12:0]}
                                     : {1'b0, n2 - 10'd1, a[12:0]};
         cmat_pkg::MAP_M180:
            prg_raw = (a < 16'hC000) ? 24'(off) : (24'(rom_bank_ff) << 14) + 24'(a[13:0]);
         default: prg_raw = 24'(off);
      endcase
   end

   // Pattern ROM raw offset
   logic [23:0] chr_raw;
   logic [2:0]  slot;
   logic [7:0]  slot_bank;
   logic [4:0]  lat_b;
   always_comb begin
      slot = va[12:10];
      if (is_sel4 && sel_mode_ff[7]) slot = slot ^ 3'd4;
      unique case (slot)
         3'd0: slot_bank = sel_bank_ff[0] & 8'hFE;
         3'd1: slot_bank = sel_bank_ff[0] | 8'h01;
         3'd2: slot_bank = sel_bank_ff[1] & 8'hFE;
         3'd3: slot_bank = sel_bank_ff[1] | 8'h01;
         3'd4: slot_bank = sel_bank_ff[2];
         3'd5: slot_bank = sel_bank_ff[3];
         3'd6: slot_bank = sel_bank_ff[4];
         default: slot_bank = sel_bank_ff[5];
      endcase
      lat_b = va[12] ? lat_bank_ff[{1'b1, latch_ff[1]}] : lat_bank_ff[{1'b0, latch_ff[0]}];
      case (mapper_ff) inside
         cmat_pkg::MAP_SERIAL: begin
            if (ser_ctrl_ff[4])
               chr_raw = {7'd0, (va[12] ? ser_bank_ff[1] : ser_bank_ff[0]), va[11:0]};
            else
               chr_raw = (24'(ser_bank_ff[0][4:1]) << 13) + 24'(va[12:0]);
         end
         cmat_pkg::MAP_M3, cmat_pkg::MAP_M87, cmat_pkg::MAP_M185, cmat_pkg::MAP_M66:
            chr_raw = {9'd0, pat_bank_ff, va[12:0]};
         cmat_pkg::MAP_SEL, cmat_pkg::MAP_SEL_FIX:
            chr_raw = {6'd0, slot_bank, va[9:0]};
         cmat_pkg::MAP_LATCH9, cmat_pkg::MAP_LATCH10:
            chr_raw = {7'd0, lat_b, va[11:0]};
         cmat_pkg::MAP_CMD:
            chr_raw = {6'd0, cmd_chr_ff[va[12:10]], va[9:0]};
         default: chr_raw = 24'(va[12:0]);
      endcase
   end

   // Target, raw offset and bank register updates for one request
   logic [4:0] sh;
   logic [2:0] cnt1;
   logic [1:0] lat_idx;
   logic [3:0] ci;
   logic [11:0] nt;
   logic [4:0] pal;
   always_comb begin
      mir_in       = mir_ff;
      ser_shift_in = ser_shift_ff;
      ser_count_in = ser_count_ff;
      ser_ctrl_in  = ser_ctrl_ff;
      ser_bank_in  = ser_bank_ff;
      rom_bank_in  = rom_bank_ff;
      pat_bank_in  = pat_bank_ff;
      sel_bank_in  = sel_bank_ff;
      sel_mode_in  = sel_mode_ff;
      lat_bank_in  = lat_bank_ff;
      latch_in     = latch_ff;
      cmd_idx_in   = cmd_idx_ff;
      cmd_chr_in   = cmd_chr_ff;
      cmd_prg_in   = cmd_prg_ff;
      target_in    = cmat_pkg::TGT_NONE;
      raw_in       = '0;
      sel_in       = cmat_pkg::MOD_NONE;
      sh           = (ser_shift_ff | (5'(v[0]) << ser_count_ff)) & 5'h1F;
      cnt1         = ser_count_ff + 3'd1;
      lat_idx      = 2'(a[15:12] - 4'hB);
      ci           = cmd_idx_ff;
      nt           = va[11:0];
      pal          = va[4:0];
      if (pal[4] && pal[1:0] == 2'd0) pal = {1'b0, pal[3:0]};

      if (req_command == cmat_pkg::CMD_CPU_READ || req_command == cmat_pkg::CMD_CPU_WRITE) begin
         if (a >= 16'h6000 && a < 16'h8000) begin
            target_in = cmat_pkg::TGT_SAVE_RAM;
            raw_in    = 24'(a - 16'h6000);
         end else if (a >= 16'h8000) begin
            if (req_command == cmat_pkg::CMD_CPU_READ) begin
               target_in = cmat_pkg::TGT_PRG_ROM;
               raw_in    = prg_raw;
               sel_in    = cmat_pkg::MOD_PRG;
            end else begin
               // Bank register write
               case (mapper_ff) inside
                  cmat_pkg::MAP_SERIAL: begin
                     if (v[7]) begin
                        ser_shift_in = '0;
                        ser_count_in = '0;
                        ser_ctrl_in  = ser_ctrl_ff | 5'h0C;
                     end else if (cnt1 == 3'd5) begin
                        ser_shift_in = '0;
                        ser_count_in = '0;
                        unique case (a[14:13])
                           2'd0: begin
                              ser_ctrl_in = sh;
                              unique case (sh[1:0])
                                 2'd0: mir_in = 2'd2;
                                 2'd1: mir_in = 2'd3;
                                 2'd2: mir_in = 2'd1;
                                 default: mir_in = 2'd0;
                              endcase
                           end
                           2'd1: ser_bank_in[0] = sh;
                           2'd2: ser_bank_in[1] = sh;
                           default: ser_bank_in[2] = sh;
                        endcase
                     end else begin
                        ser_shift_in = sh;
                        ser_count_in = cnt1;
                     end
                  end
                  cmat_pkg::MAP_M2: rom_bank_in = v & 8'(n_prg - 9'd1);
                  cmat_pkg::MAP_M3, cmat_pkg::MAP_M185: pat_bank_in = v[1:0];
                  cmat_pkg::MAP_SEL, cmat_pkg::MAP_SEL_FIX: begin
                     if (a < 16'hA000) begin
                        if (a[0]) sel_bank_in[sel_mode_ff[2:0]] = v;
                        else sel_mode_in = is_sel4 ? v : {5'd0, v[2:0]};
                     end else if (a < 16'hC000 && is_sel4 && !a[0]) begin
                        mir_in = v[0] ? 2'd0 : 2'd1;
                     end
                  end
                  cmat_pkg::MAP_M7: begin
                     rom_bank_in = {5'd0, v[2:0]};
                     mir_in      = v[4] ? 2'd3 : 2'd2;
                  end
                  cmat_pkg::MAP_LATCH9, cmat_pkg::MAP_LATCH10: begin
                     if (a < 16'hB000) rom_bank_in = {4'd0, v[3:0]};
                     else if (a < 16'hF000) lat_bank_in[lat_idx] = v[4:0];
                     else mir_in = v[0] ? 2'd0 : 2'd1;
                  end
                  cmat_pkg::MAP_M34: rom_bank_in = v;
                  cmat_pkg::MAP_M66: begin
                     rom_bank_in = {6'd0, v[5:4]};
                     pat_bank_in = v[1:0];
                  end
                  cmat_pkg::MAP_CMD: begin
                     if (a < 16'hA000) cmd_idx_in = v[3:0];
                     else if (a < 16'hC000) begin
                        if (!ci[3]) cmd_chr_in[ci[2:0]] = v;
                        else if (ci < 4'd12) cmd_prg_in[ci[1:0]] = v[5:0];
                        else if (ci == 4'd12) begin
                           unique case (v[1:0])
                              2'd0: mir_in = 2'd1;
                              2'd1: mir_in = 2'd0;
                              2'd2: mir_in = 2'd2;
                              default: mir_in = 2'd3;
                           endcase
                        end
                     end
                  end
                  cmat_pkg::MAP_M87: pat_bank_in = {v[0], v[1]};
                  cmat_pkg::MAP_M94: rom_bank_in = {5'd0, v[4:2]};
                  cmat_pkg::MAP_M180: rom_bank_in = {5'd0, v[2:0]};
                  default: ;
               endcase
            end
         end
      end else begin
         if (va < 14'h2000) begin
            if (chr_ram_ff) begin
               target_in = cmat_pkg::TGT_CHR_RAM;
               raw_in    = 24'(va[12:0]);
            end else if (req_command == cmat_pkg::CMD_VID_READ) begin
               target_in = cmat_pkg::TGT_CHR_ROM;
               raw_in    = chr_raw;
               sel_in    = cmat_pkg::MOD_CHR;
               // Latch triggers, after the bank lookup
               if (mapper_ff == cmat_pkg::MAP_LATCH9 || mapper_ff == cmat_pkg::MAP_LATCH10) begin
                  if (va == 14'h0FD8) latch_in[0] = 1'b0;
                  else if (va == 14'h0FE8) latch_in[0] = 1'b1;
                  else if (va[13:3] == 11'h3FB) latch_in[1] = 1'b0;
                  else if (va[13:3] == 11'h3FD) latch_in[1] = 1'b1;
               end
            end
         end else if (va < 14'h3F00) begin
            target_in = cmat_pkg::TGT_NAMETABLE;
            unique case (mir_ff)
               2'd0: raw_in = 24'({nt[11], nt[9:0]});
               2'd1: raw_in = 24'(nt[10:0]);
               2'd2: raw_in = 24'(nt[9:0]);
               default: raw_in = 24'({1'b1, nt[9:0]});
            endcase
         end else begin
            target_in = cmat_pkg::TGT_PALETTE;
            raw_in    = 24'(pal);
         end
      end
   end

   // Configuration and bank state
   always_ff @(posedge clock) begin
      if (reset) begin
         mapper_ff    <= '0;
         prg_count_ff <= 9'd2;
         chr_count_ff <= 9'd1;
         chr_ram_ff   <= 1'b0;
         mir_ff       <= '0;
         ser_shift_ff <= '0;
         ser_count_ff <= '0;
         ser_ctrl_ff  <= '0;
         ser_bank_ff  <= '{default: '0};
         rom_bank_ff  <= '0;
         pat_bank_ff  <= '0;
         sel_bank_ff  <= '{default: '0};
         sel_mode_ff  <= '0;
         lat_bank_ff  <= '{default: '0};
         latch_ff     <= '{default: '0};
         cmd_idx_ff   <= '0;
         cmd_chr_ff   <= '{default: '0};
         cmd_prg_ff   <= '{default: '0};
      end else if (dp_cmd.load) begin
         mir_ff       <= mir_in;
         ser_shift_ff <= ser_shift_in;
         ser_count_ff <= ser_count_in;
         ser_ctrl_ff  <= ser_ctrl_in;
         ser_bank_ff  <= ser_bank_in;
         rom_bank_ff  <= rom_bank_in;
         pat_bank_ff  <= pat_bank_in;
         sel_bank_ff  <= sel_bank_in;
         sel_mode_ff  <= sel_mode_in;
         lat_bank_ff  <= lat_bank_in;
         latch_ff     <= latch_in;
         cmd_idx_ff   <= cmd_idx_in;
         cmd_chr_ff   <= cmd_chr_in;
         cmd_prg_ff   <= cmd_prg_in;
      end else if (csr_write) begin
         unique case (csr_index)
            cmat_pkg::CSR_MAPPER:    mapper_ff    <= csr_data[7:0];
            cmat_pkg::CSR_PRG_COUNT: prg_count_ff <= csr_data;
            cmat_pkg::CSR_CHR_COUNT: chr_count_ff <= csr_data;
            cmat_pkg::CSR_CHR_RAM:   chr_ram_ff   <= csr_data[0];
            // Header mirroring only reloads the live mode
            cmat_pkg::CSR_MIRRORING: mir_ff       <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Restoring remainder, one quotient bit a step
   logic [8:0] trial;
   logic [8:0] trial_sub;
   assign trial     = {rem_ff, num_ff[cmat_pkg::NumWidth-1]};
   assign trial_sub = trial - divisor;
   assign dp_status.last_step = (step_ff == cmat_pkg::StepWidth'(cmat_pkg::DivSteps - 1));

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         target_ff <= target_in;
         raw_ff    <= raw_in;
         sel_ff    <= sel_in;
         num_ff    <= (sel_in == cmat_pkg::MOD_PRG) ? 11'(raw_in[23:14]) : raw_in[23:13];
         rem_ff    <= '0;
         step_ff   <= '0;
      end else if (dp_cmd.step) begin
         num_ff  <= {num_ff[cmat_pkg::NumWidth-2:0], 1'b0};
         rem_ff  <= (trial >= divisor) ? trial_sub[7:0] : trial[7:0];
         step_ff <= step_ff + 1'b1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (dp_cmd.finish) begin
         out_target_ff <= target_ff;
         case (sel_ff)
            cmat_pkg::MOD_PRG: out_offset_ff <= {rem_ff, raw_ff[13:0]};
            cmat_pkg::MOD_CHR: out_offset_ff <= {1'b0, rem_ff, raw_ff[12:0]};
            default:           out_offset_ff <= raw_ff[21:0];
         endcase
      end
   end

   assign rsp_target = out_target_ff;
   assign rsp_offset = out_offset_ff;

endmodule
`default_nettype wire

### sv/cmat_chk.sv
// Port-level checks for the cartridge address translator, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module cmat_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [23:0] rsp_tdata,
   input wire [2:0]  rsp_tuser
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // One request in flight
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // No target means no offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == 3'd0 |-> rsp_tdata == 24'd0)
      else $error("offset without target");

   // Fill bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:22] == 2'b00)
      else $error("fill bits set");

endmodule

bind cartridge_mapper_address_translation cmat_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
